// File: hw/rtl/ccsx_pkg.sv
// Shared types, constants and helper functions for the ChaCha20 stream XOR block.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.
package ccsx_pkg;

  localparam int DOUBLE_ROUNDS_DEF = 10;
  localparam int QUEUE_DEPTH_DEF   = 2;

  localparam int DATA_W       = 8;
  localparam int POS_W        = 38;
  localparam int IDX_W        = 6;
  localparam int CNT_W        = 32;
  localparam int WORD_W       = 32;
  localparam int NWORDS       = 16;
  localparam int KEY_PARTS    = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int NONCE_LO_W   = 64;
  localparam int NONCE_HI_W   = 32;

  localparam logic [WORD_W-1:0] SIGMA0 = 32'h61707865;
  localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320646e;
  localparam logic [WORD_W-1:0] SIGMA2 = 32'h79622d32;
  localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b206574;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_PART_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_PART_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_PART_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_PART_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HIGH = 3'd5;

  typedef logic [NWORDS-1:0][WORD_W-1:0]        words_t;
  typedef logic [KEY_PARTS-1:0][CFG_DATA_W-1:0] key_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              start;
    logic [POS_W-1:0]  pos;
  } item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_status_t;

  typedef enum logic {
    ST_IDLE,
    ST_BLOCK
  } back_state_t;

  // Assemble the 16-word block input: constants, key, counter, nonce
  function automatic words_t build_init(key_t key, logic [NONCE_LO_W-1:0] nonce_lo,
                                        logic [NONCE_HI_W-1:0] nonce_hi,
                                        logic [CNT_W-1:0] ctr);
    words_t w;
    w[0] = SIGMA0;
    w[1] = SIGMA1;
    w[2] = SIGMA2;
    w[3] = SIGMA3;
    for (int i = 0; i < KEY_PARTS; i++) begin
      w[4 + 2 * i] = key[i][WORD_W-1:0];
      w[5 + 2 * i] = key[i][CFG_DATA_W-1:WORD_W];
    end
    w[12] = ctr;
    w[13] = nonce_lo[WORD_W-1:0];
    w[14] = nonce_lo[NONCE_LO_W-1:WORD_W];
    w[15] = nonce_hi;
    return w;
  endfunction

  // Word index of role a/b/c/d (0..3) for a lane in a column or diagonal round
  function automatic logic [3:0] qr_index(logic [1:0] lane, logic diag, logic [1:0] role);
    logic [1:0] col;
    col = lane + (diag ? role : 2'd0);
    return {role, col};
  endfunction

  // Rotate left by the amount of the given quarter-round step
  function automatic logic [WORD_W-1:0] rotl_step(logic [WORD_W-1:0] v, logic [1:0] step);
    logic [WORD_W-1:0] r;
    unique case (step)
      2'd0: r = {v[15:0], v[31:16]};
      2'd1: r = {v[19:0], v[31:20]};
      2'd2: r = {v[23:0], v[31:24]};
      2'd3: r = {v[24:0], v[31:25]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/ccsx_front.sv
// Front end: input item queue between the push/full port and the back end.
// Depends on ccsx_pkg for the item type.
module ccsx_front #(
  parameter int QUEUE_DEPTH = ccsx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  ccsx_pkg::item_t item_in,
  input  logic            q_pop,
  output logic            head_valid,
  output ccsx_pkg::item_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ccsx_pkg::item_t  mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = q_pop && head_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the accepted item
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

// File: hw/rtl/ccsx_core.sv
// Block generator: iterative ChaCha20 rounds, one add-xor-rotate step per lane per cycle.
// Depends on ccsx_pkg for the word array type and round helpers.
module ccsx_core #(
  parameter int DOUBLE_ROUNDS = ccsx_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   go,
  input  ccsx_pkg::words_t       init,
  output ccsx_pkg::core_status_t status,
  output ccsx_pkg::words_t       ks
);

  localparam int DRW = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

  ccsx_pkg::words_t w_r, w_nxt;
  logic             busy_r, done_r;
  logic [1:0]       step_r;
  logic             diag_r;
  logic [DRW-1:0]   dr_r;
  logic             last_step;

  // One quarter-round step on all four lanes
  always_comb begin
    logic [3:0]                  xi, yi, zi;
    logic [ccsx_pkg::WORD_W-1:0] sum;
    w_nxt = w_r;
    for (int lane = 0; lane < 4; lane++) begin
      if (!step_r[0]) begin
        xi = ccsx_pkg::qr_index(2'(lane), diag_r, 2'd0);
        yi = ccsx_pkg::qr_index(2'(lane), diag_r, 2'd1);
        zi = ccsx_pkg::qr_index(2'(lane), diag_r, 2'd3);
      end else begin
        xi = ccsx_pkg::qr_index(2'(lane), diag_r, 2'd2);
        yi = ccsx_pkg::qr_index(2'(lane), diag_r, 2'd3);
        zi = ccsx_pkg::qr_index(2'(lane), diag_r, 2'd1);
      end
      sum       = w_r[xi] + w_r[yi];
      w_nxt[xi] = sum;
      w_nxt[zi] = ccsx_pkg::rotl_step(w_r[zi] ^ sum, step_r);
    end
  end

  assign last_step = busy_r && (step_r == 2'd3) && diag_r &&
                     (dr_r == DRW'(DOUBLE_ROUNDS - 1));

  // Step, half-round and double-round counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
      diag_r <= 1'b0;
      dr_r   <= '0;
    end else begin
      done_r <= last_step;
      if (go) begin
        busy_r <= 1'b1;
        step_r <= '0;
        diag_r <= 1'b0;
        dr_r   <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == 2'd3) begin
          diag_r <= ~diag_r;
          if (diag_r) begin
            dr_r <= dr_r + 1'b1;
          end
        end
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Working state
  always_ff @(posedge clk) begin
    if (go) begin
      w_r <= init;
    end else if (busy_r) begin
      w_r <= w_nxt;
    end
  end

  // Feed-forward add of the block input
  always_comb begin
    for (int i = 0; i < ccsx_pkg::NWORDS; i++) begin
      ks[i] = w_r[i] + init[i];
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

// File: hw/rtl/ccsx_back.sv
// Back end: stream position, keystream block store, byte XOR and result register.
// Depends on ccsx_pkg; drives the block generator in ccsx_core.
module ccsx_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              head_valid,
  input  ccsx_pkg::item_t                   head,
  output logic                              q_pop,
  input  ccsx_pkg::key_t                    key,
  input  logic [ccsx_pkg::NONCE_LO_W-1:0]   nonce_lo,
  input  logic [ccsx_pkg::NONCE_HI_W-1:0]   nonce_hi,
  output logic                              core_go,
  output ccsx_pkg::words_t                  core_init,
  input  ccsx_pkg::core_status_t            core_status,
  input  ccsx_pkg::words_t                  core_ks,
  output logic [ccsx_pkg::DATA_W-1:0]       out_byte,
  output logic                              empty,
  input  logic                              pop
);

  ccsx_pkg::back_state_t            state_r, state_nxt;
  logic [ccsx_pkg::CNT_W-1:0]       counter_r, counter_nxt;
  logic [ccsx_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic                             ready_r, ready_nxt;
  logic                             start_done_r, start_done_nxt;
  logic                             out_valid_r, out_valid_nxt;
  ccsx_pkg::words_t                 ks_r;
  logic [ccsx_pkg::DATA_W-1:0]      out_byte_r;
  logic [ccsx_pkg::DATA_W-1:0]      ks_byte;
  logic                             start_eff, slot_free, out_load, ks_load;

  assign start_eff = head_valid && head.start && !start_done_r;
  assign slot_free = !out_valid_r || pop;
  assign ks_byte   = ks_r[idx_r[ccsx_pkg::IDX_W-1:2]][{idx_r[1:0], 3'b000} +: ccsx_pkg::DATA_W];
  assign core_init = ccsx_pkg::build_init(key, nonce_lo, nonce_hi, counter_r);

  // Sequence: load position, make block, emit byte
  always_comb begin
    state_nxt      = state_r;
    counter_nxt    = counter_r;
    idx_nxt        = idx_r;
    ready_nxt      = ready_r;
    start_done_nxt = start_done_r;
    out_valid_nxt  = out_valid_r && !pop;
    q_pop          = 1'b0;
    core_go        = 1'b0;
    out_load       = 1'b0;
    ks_load        = 1'b0;
    unique case (state_r)
      ccsx_pkg::ST_IDLE: begin
        if (head_valid) begin
          priority if (start_eff) begin
            counter_nxt    = head.pos[ccsx_pkg::POS_W-1:ccsx_pkg::IDX_W];
            idx_nxt        = head.pos[ccsx_pkg::IDX_W-1:0];
            ready_nxt      = 1'b0;
            start_done_nxt = 1'b1;
          end else if (!ready_r) begin
            core_go   = 1'b1;
            state_nxt = ccsx_pkg::ST_BLOCK;
          end else if (slot_free) begin
            q_pop          = 1'b1;
            out_load       = 1'b1;
            out_valid_nxt  = 1'b1;
            start_done_nxt = 1'b0;
            if (&idx_r) begin
              idx_nxt     = '0;
              counter_nxt = counter_r + 1'b1;
              ready_nxt   = 1'b0;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        end
      end
      ccsx_pkg::ST_BLOCK: begin
        if (core_status.done) begin
          ks_load   = 1'b1;
          ready_nxt = 1'b1;
          state_nxt = ccsx_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ccsx_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ccsx_pkg::ST_IDLE;
      counter_r    <= '0;
      idx_r        <= '0;
      ready_r      <= 1'b0;
      start_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      counter_r    <= counter_nxt;
      idx_r        <= idx_nxt;
      ready_r      <= ready_nxt;
      start_done_r <= start_done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Hold keystream block and result byte
  always_ff @(posedge clk) begin
    if (ks_load) begin
      ks_r <= core_ks;
    end
    if (out_load) begin
      out_byte_r <= head.data ^ ks_byte;
    end
  end

  assign out_byte = out_byte_r;
  assign empty    = !out_valid_r;

  a_go_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    core_go |-> (state_r == ccsx_pkg::ST_IDLE) && !ready_r && !core_status.busy)
    else $error("block generator started while busy or with a block ready");

  a_pop_needs_block: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> ready_r && !start_eff && head_valid)
    else $error("item consumed without a current keystream block");

  a_done_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    core_status.done |-> (state_r == ccsx_pkg::ST_BLOCK))
    else $error("block done outside block state");

  a_block_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ccsx_pkg::ST_BLOCK) && core_status.done |=>
      ready_r && (state_r == ccsx_pkg::ST_IDLE))
    else $error("finished block not marked ready");

endmodule

// File: hw/rtl/chacha20_stream_xor.sv
// ChaCha20 stream XOR: one data byte in, the byte XORed with the keystream out.
// A byte inside a ready block is XORed into the result register, which drops empty, when taken; a byte
// that needs a new block waits for the shared quarter-round step unit to finish it; a start item
// first loads the position. Throughput: 1 byte per cycle inside a block while out_byte is popped.
// Reset (rst_n low, synchronous): key and nonce clear, counter and byte index go to 0,
// no block is held, input queue and result register empty. Depends on ccsx_pkg.
module chacha20_stream_xor #(
  parameter int DOUBLE_ROUNDS = ccsx_pkg::DOUBLE_ROUNDS_DEF,
  parameter int QUEUE_DEPTH   = ccsx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic [ccsx_pkg::DATA_W-1:0]        in_data_byte,
  input  logic                               in_start_of_run,
  input  logic [ccsx_pkg::POS_W-1:0]         in_stream_position,
  output logic                               empty,
  input  logic                               pop,
  output logic [ccsx_pkg::DATA_W-1:0]        out_byte,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ccsx_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ccsx_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ccsx_pkg::key_t                   key_r;
  logic [ccsx_pkg::NONCE_LO_W-1:0]  nonce_lo_r;
  logic [ccsx_pkg::NONCE_HI_W-1:0]  nonce_hi_r;

  ccsx_pkg::item_t                  item_in, head;
  logic                             head_valid, q_pop, core_go;
  ccsx_pkg::words_t                 core_init, core_ks;
  ccsx_pkg::core_status_t           core_status;

  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r      <= '0;
      nonce_lo_r <= '0;
      nonce_hi_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ccsx_pkg::CFG_KEY_PART_0: key_r[0]   <= cfg_data;
        ccsx_pkg::CFG_KEY_PART_1: key_r[1]   <= cfg_data;
        ccsx_pkg::CFG_KEY_PART_2: key_r[2]   <= cfg_data;
        ccsx_pkg::CFG_KEY_PART_3: key_r[3]   <= cfg_data;
        ccsx_pkg::CFG_NONCE_LOW:  nonce_lo_r <= cfg_data;
        ccsx_pkg::CFG_NONCE_HIGH: nonce_hi_r <= cfg_data[ccsx_pkg::NONCE_HI_W-1:0];
        default: ;
      endcase
    end
  end

  assign item_in.data  = in_data_byte;
  assign item_in.start = in_start_of_run;
  assign item_in.pos   = in_stream_position;

  ccsx_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .item_in    (item_in),
    .q_pop      (q_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ccsx_core #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (core_go),
    .init   (core_init),
    .status (core_status),
    .ks     (core_ks)
  );

  ccsx_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head        (head),
    .q_pop       (q_pop),
    .key         (key_r),
    .nonce_lo    (nonce_lo_r),
    .nonce_hi    (nonce_hi_r),
    .core_go     (core_go),
    .core_init   (core_init),
    .core_status (core_status),
    .core_ks     (core_ks),
    .out_byte    (out_byte),
    .empty       (empty),
    .pop         (pop)
  );

endmodule
